// ===== rtl/iir_direct_form_filter_core_macros.svh =====
// Assertion helpers shared by the filter core modules.
// Each macro takes a label, the clock, the reset and two expressions.
`ifndef IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define IIRDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define IIRDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define IIRDF_ASSERT_SAME(label, clk, rst, ante, cons)
`define IIRDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/iirdf_pkg.sv =====
`timescale 1ns / 1ps
package iirdf_pkg;

   // Coefficient fields are signed Q4.12 words, four to a register, three in FB_HIGH.
   localparam int COEF_BITS   = 16;
   localparam int COEF_FIELDS = 8;
   localparam int FB_HIGH_W   = 48;

   // Configuration port geometry: four registers at 8-byte spacing; the first three are 64 bits, FB_HIGH is 48 bits.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      REG_FF_LOW  = 2'd0,
      REG_FF_HIGH = 2'd1,
      REG_FB_LOW  = 2'd2,
      REG_FB_HIGH = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mac;
      logic writeback;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/iirdf_regs.sv =====
`timescale 1ns / 1ps
module iirdf_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [iirdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [iirdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [iirdf_pkg::CSR_DATA_W-1:0]    ff_low,
   output logic [iirdf_pkg::CSR_DATA_W-1:0]    ff_high,
   output logic [iirdf_pkg::CSR_DATA_W-1:0]    fb_low,
   output logic [iirdf_pkg::FB_HIGH_W-1:0]     fb_high
);

   logic [iirdf_pkg::CSR_DATA_W-1:0] ff_low_ff;
   logic [iirdf_pkg::CSR_DATA_W-1:0] ff_high_ff;
   logic [iirdf_pkg::CSR_DATA_W-1:0] fb_low_ff;
   logic [iirdf_pkg::FB_HIGH_W-1:0]  fb_high_ff;
   logic                             wr_en;
   iirdf_pkg::reg_index_type         reg_sel;

   // The port never waits.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = iirdf_pkg::reg_index_type'(csr_paddr[4:3]);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_low_ff  <= '0;
         ff_high_ff <= '0;
         fb_low_ff  <= '0;
         fb_high_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            iirdf_pkg::REG_FF_LOW:  ff_low_ff  <= csr_pwdata;
            iirdf_pkg::REG_FF_HIGH: ff_high_ff <= csr_pwdata;
            iirdf_pkg::REG_FB_LOW:  fb_low_ff  <= csr_pwdata;
            iirdf_pkg::REG_FB_HIGH: fb_high_ff <= csr_pwdata[iirdf_pkg::FB_HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (reg_sel)
         iirdf_pkg::REG_FF_LOW:  csr_prdata = ff_low_ff;
         iirdf_pkg::REG_FF_HIGH: csr_prdata = ff_high_ff;
         iirdf_pkg::REG_FB_LOW:  csr_prdata = fb_low_ff;
         iirdf_pkg::REG_FB_HIGH: csr_prdata = iirdf_pkg::CSR_DATA_W'(fb_high_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign ff_low  = ff_low_ff;
   assign ff_high = ff_high_ff;
   assign fb_low  = fb_low_ff;
   assign fb_high = fb_high_ff;

endmodule

// ===== rtl/iirdf_ctrl.sv =====
`timescale 1ns / 1ps
`include "iir_direct_form_filter_core_macros.svh"
module iirdf_ctrl #(
   parameter int MAX_TAPS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  iirdf_pkg::status_type                  status,
   output iirdf_pkg::cmd_type                     cmd,
   output logic [$clog2(2*MAX_TAPS-1)-1:0]        step
);

   localparam int STEP_W = $clog2(2*MAX_TAPS-1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2*MAX_TAPS-2);

   iirdf_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iirdf_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = iirdf_pkg::ST_MAC;
         end
         iirdf_pkg::ST_MAC: begin
            if (step_ff == LAST_STEP) state_in = iirdf_pkg::ST_DRAIN;
         end
         iirdf_pkg::ST_DRAIN: begin
            state_in = iirdf_pkg::ST_WRITE;
         end
         iirdf_pkg::ST_WRITE: begin
            if (status.out_free) state_in = iirdf_pkg::ST_IDLE;
         end
         default: state_in = iirdf_pkg::ST_IDLE;
      endcase
   end

   // Outputs: commands to the datapath and the input handshake.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         iirdf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         iirdf_pkg::ST_MAC: begin
            cmd.mac = 1'b1;
         end
         iirdf_pkg::ST_DRAIN: ;
         iirdf_pkg::ST_WRITE: begin
            cmd.writeback = status.out_free;
         end
         default: ;
      endcase
   end

   // Product step counter, one step per cycle in the MAC state.
   assign step_in = (state_ff == iirdf_pkg::ST_MAC) ? step_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iirdf_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign step = step_ff;

   `IIRDF_ASSERT_SAME(a_wb_needs_room, clock, reset, cmd.writeback, status.out_free)
   `IIRDF_ASSERT_SAME(a_step_bound, clock, reset, state_ff == iirdf_pkg::ST_MAC, step_ff <= LAST_STEP)
   `IIRDF_ASSERT_NEXT(a_load_starts, clock, reset, cmd.load, state_ff == iirdf_pkg::ST_MAC && step_ff == '0)

endmodule

// ===== rtl/iirdf_datapath.sv =====
`timescale 1ns / 1ps
`include "iir_direct_form_filter_core_macros.svh"
module iirdf_datapath #(
   parameter int MAX_TAPS       = 8,
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iirdf_pkg::cmd_type                  cmd,
   input  logic [$clog2(2*MAX_TAPS-1)-1:0]     step,
   output iirdf_pkg::status_type               status,
   input  logic signed [SAMPLE_BITS-1:0]       sample_in,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]    ff_low,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]    ff_high,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]    fb_low,
   input  logic [iirdf_pkg::FB_HIGH_W-1:0]     fb_high,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       filtered_out,
   output logic                                clipped
);

   localparam int CB         = iirdf_pkg::COEF_BITS;
   localparam int STEP_W     = $clog2(2*MAX_TAPS-1);
   localparam int TAP_W      = $clog2(MAX_TAPS);
   localparam int IDX_W      = TAP_W + 1;
   localparam int HIST_DEPTH = MAX_TAPS - 1;
   localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int PROD_W     = SAMPLE_BITS + CB;
   localparam int ACC_W      = SAMPLE_BITS + CB + COEF_FRAC_BITS + $clog2(2*MAX_TAPS);
   localparam int Y_W        = ACC_W - COEF_FRAC_BITS;
   localparam logic signed [Y_W-1:0]   Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
   localparam logic signed [Y_W-1:0]   Y_MIN = -Y_MAX - Y_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS-1));

   // History storage and working registers.
   logic signed [SAMPLE_BITS-1:0] in_hist_ff  [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] out_hist_ff [HIST_DEPTH];
   logic [SLOT_W-1:0]             newest_ff, newest_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          sub_ff;
   logic                          mul_valid_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic                          rsp_clip_ff;

   logic signed [CB-1:0]          b_coef [iirdf_pkg::COEF_FIELDS];
   logic signed [CB-1:0]          a_coef [iirdf_pkg::COEF_FIELDS];
   logic [STEP_W:0]               k_wide;
   logic [TAP_W-1:0]              k;
   logic [TAP_W-1:0]              k_eff;
   logic [TAP_W+2:0]              k_ext;
   logic [2:0]                    k_field;
   logic                          k_in_range;
   logic [IDX_W-1:0]              slot_raw;
   logic [IDX_W-1:0]              slot_wrap;
   logic [SLOT_W-1:0]             rd_slot;
   logic                          is_feedback;
   logic signed [SAMPLE_BITS-1:0] op_sample;
   logic signed [CB-1:0]          op_coef;
   logic signed [ACC_W-1:0]       rounded;
   logic signed [Y_W-1:0]         y_full;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          y_clip;

   // Unpack the coefficient registers; the feedback list starts at a1.
   always_comb begin
      for (int i = 0; i < iirdf_pkg::COEF_FIELDS; i++) begin
         if (i < 4) b_coef[i] = ff_low[16*i +: 16];
         else       b_coef[i] = ff_high[16*(i-4) +: 16];
      end
      a_coef[0] = '0;
      for (int i = 1; i < iirdf_pkg::COEF_FIELDS; i++) begin
         if (i < 5) a_coef[i] = fb_low[16*(i-1) +: 16];
         else       a_coef[i] = fb_high[16*(i-5) +: 16];
      end
   end

   // Step 0 is b0*x; odd steps are b_k*x[n-k], even steps a_k*y[n-k].
   assign k_wide      = ({1'b0, step} + 1'b1) >> 1;
   assign k           = k_wide[TAP_W-1:0];
   assign is_feedback = (step != '0) && !step[0];
   assign k_ext       = {3'b000, k};
   assign k_field     = k_ext[2:0];
   assign k_in_range  = (k_ext[TAP_W+2:3] == '0);

   // Tap k reads the history slot k-1 places behind the newest entry.
   assign k_eff     = (k == '0) ? TAP_W'(1) : k;
   assign slot_raw  = IDX_W'(newest_ff) + IDX_W'(HIST_DEPTH) + IDX_W'(1) - IDX_W'(k_eff);
   assign slot_wrap = (slot_raw >= IDX_W'(HIST_DEPTH)) ? slot_raw - IDX_W'(HIST_DEPTH)
                                                       : slot_raw;
   assign rd_slot   = SLOT_W'(slot_wrap);

   // Operand selection for the shared multiplier.
   always_comb begin
      if (step == '0)       op_sample = x_ff;
      else if (is_feedback) op_sample = out_hist_ff[rd_slot];
      else                  op_sample = in_hist_ff[rd_slot];

      if (!k_in_range)      op_coef = '0;
      else if (is_feedback) op_coef = a_coef[k_field];
      else                  op_coef = b_coef[k_field];
   end

   assign prod_in = PROD_W'(op_sample) * PROD_W'(op_coef);

   // Accumulate the registered product in the cycle after it is formed; a load clears the sum.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (mul_valid_ff) begin
         if (sub_ff) acc_in = acc_ff - ACC_W'(prod_ff);
         else        acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Round half up, drop the fraction bits, then saturate.
   assign rounded = acc_ff + ROUND_HALF;
   assign y_full  = Y_W'(rounded >>> COEF_FRAC_BITS);

   always_comb begin
      y_clip = 1'b0;
      y_sat  = y_full[SAMPLE_BITS-1:0];
      if (y_full > Y_MAX) begin
         y_sat  = Y_MAX[SAMPLE_BITS-1:0];
         y_clip = 1'b1;
      end else if (y_full < Y_MIN) begin
         y_sat  = Y_MIN[SAMPLE_BITS-1:0];
         y_clip = 1'b1;
      end
   end

   assign newest_in = (newest_ff == SLOT_W'(HIST_DEPTH-1)) ? '0 : newest_ff + 1'b1;

   // Output register: filled on writeback, emptied when the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.writeback)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff    <= '0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
      end else begin
         mul_valid_ff <= cmd.mac;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         if (cmd.writeback) begin
            newest_ff              <= newest_in;
            in_hist_ff[newest_in]  <= x_ff;
            out_hist_ff[newest_in] <= y_sat;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) x_ff <= sample_in;
      if (cmd.mac) begin
         prod_ff <= prod_in;
         sub_ff  <= is_feedback;
      end
      if (cmd.writeback) begin
         rsp_data_ff <= y_sat;
         rsp_clip_ff <= y_clip;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign filtered_out = rsp_data_ff;
   assign clipped      = rsp_clip_ff;

   `IIRDF_ASSERT_SAME(a_newest_bound, clock, reset, 1'b1, newest_ff <= SLOT_W'(HIST_DEPTH-1))
   `IIRDF_ASSERT_NEXT(a_wb_fills_out, clock, reset, cmd.writeback, rsp_valid_ff)
   `IIRDF_ASSERT_NEXT(a_load_clears, clock, reset, cmd.load, acc_ff == '0 && !mul_valid_ff)

endmodule

// ===== rtl/iir_direct_form_filter_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Accepted when               Carries
// req_      in         req_tvalid & req_tready     tdata: sample_in
// rsp_      out        rsp_tvalid & rsp_tready     tdata: filtered_out, tuser: clipped
// csr_      in         psel & penable & pwrite     four coefficient registers at 8*i
//
// For each accepted item, one shared multiplier forms 2*MAX_TAPS-1 products,
// one per cycle, followed by a last accumulate and the round/saturate write
// that puts the result in the output register.
// A new item is taken once the previous one is written to the output register,
// even while that result still waits; a stalled output holds the next write.
// Synchronous active-high reset clears the coefficients and both histories.
module iir_direct_form_filter_core #(
   parameter int MAX_TAPS       = 8,
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample_in in the low bits, zero padded to whole bytes
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // filtered_out in the low bits, zero padded to whole bytes
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,
   // clipped
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [iirdf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [iirdf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   localparam int TDATA_W = ((SAMPLE_BITS+7)/8)*8;
   localparam int STEP_W  = $clog2(2*MAX_TAPS-1);

   logic [iirdf_pkg::CSR_DATA_W-1:0] ff_low;
   logic [iirdf_pkg::CSR_DATA_W-1:0] ff_high;
   logic [iirdf_pkg::CSR_DATA_W-1:0] fb_low;
   logic [iirdf_pkg::FB_HIGH_W-1:0]  fb_high;
   iirdf_pkg::cmd_type               cmd;
   iirdf_pkg::status_type            status;
   logic [STEP_W-1:0]                step;
   logic signed [SAMPLE_BITS-1:0]    filtered_out;

   iirdf_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ff_low      (ff_low),
      .ff_high     (ff_high),
      .fb_low      (fb_low),
      .fb_high     (fb_high)
   );

   iirdf_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .step       (step)
   );

   iirdf_datapath #(
      .MAX_TAPS       (MAX_TAPS),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .step         (step),
      .status       (status),
      .sample_in    (req_tdata[SAMPLE_BITS-1:0]),
      .ff_low       (ff_low),
      .ff_high      (ff_high),
      .fb_low       (fb_low),
      .fb_high      (fb_high),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .filtered_out (filtered_out),
      .clipped      (rsp_tuser)
   );

   assign rsp_tdata = TDATA_W'({1'b0, filtered_out});

endmodule
